// ===== rtl/core/script_lexer_tokenizer_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the script lexer tokenizer
// Clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef SCRIPT_LEXER_TOKENIZER_ASSERT_SVH
`define SCRIPT_LEXER_TOKENIZER_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define LEX_ASSERT_IMP(lbl, ant, con, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (con)) \
        else $error(msg);

// next-cycle implication
`define LEX_ASSERT_NXT(lbl, ant, con, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (con)) \
        else $error(msg);

`else

`define LEX_ASSERT_IMP(lbl, ant, con, msg)
`define LEX_ASSERT_NXT(lbl, ant, con, msg)

`endif

`endif

// ===== rtl/core/lextok_pkg.sv =====
// ----------------------------------------------------------------------------
// lextok_pkg
// Scan modes, token kinds, character codes and keyword/operator tables.
// ----------------------------------------------------------------------------
`default_nettype none

package lextok_pkg;

    typedef enum logic [2:0] {
        MODE_IDLE,
        MODE_COMMENT,
        MODE_WORD,
        MODE_NUM_INT,
        MODE_NUM_FRAC,
        MODE_STRING,
        MODE_SYM
    } scan_mode_t;

    localparam logic [4:0] KIND_EOF     = 5'd0;
    localparam logic [4:0] KIND_EOL     = 5'd1;
    localparam logic [4:0] KIND_NAME    = 5'd2;
    localparam logic [4:0] KIND_NUMBER  = 5'd3;
    localparam logic [4:0] KIND_STRING  = 5'd4;
    localparam logic [4:0] KIND_KW_BASE = 5'd5;
    localparam logic [4:0] KIND_OP_BASE = 5'd17;
    localparam logic [4:0] KIND_SYMBOL  = 5'd23;

    localparam logic [1:0] ERR_NONE        = 2'd0;
    localparam logic [1:0] ERR_BAD_NUMBER  = 2'd1;
    localparam logic [1:0] ERR_OPEN_STRING = 2'd2;

    localparam logic [7:0] CH_NUL       = 8'h00;
    localparam logic [7:0] CH_TAB       = 8'h09;
    localparam logic [7:0] CH_LF        = 8'h0A;
    localparam logic [7:0] CH_CR        = 8'h0D;
    localparam logic [7:0] CH_SPACE     = 8'h20;
    localparam logic [7:0] CH_QUOTE     = 8'h22;
    localparam logic [7:0] CH_HASH      = 8'h23;
    localparam logic [7:0] CH_RPAREN    = 8'h29;
    localparam logic [7:0] CH_DOT       = 8'h2E;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_RBRACK    = 8'h5D;
    localparam logic [7:0] CH_UNDERLINE = 8'h5F;
    localparam logic [7:0] CH_RBRACE    = 8'h7D;

    localparam int MAX_KEYWORD_CHARS = 8;
    localparam int PREFIX_BITS       = 8 * MAX_KEYWORD_CHARS;
    localparam int KW_COUNT          = 12;
    localparam int OP_COUNT          = 6;
    localparam int RUN_BITS          = 16;

    // QDEPTH entries of result queue; one byte pushes at most MAX_PUSH results
    localparam int QDEPTH    = 4;
    localparam int QPTR_BITS = 2;
    localparam int MAX_PUSH  = 3;

    // keywords packed first byte most significant, right aligned
    localparam logic [PREFIX_BITS-1:0] KW_TEXT [KW_COUNT] = '{
        64'h0000_0000_006E_696C,   // nil
        64'h0000_0000_7472_7565,   // true
        64'h0000_0066_616C_7365,   // false
        64'h0000_0000_6675_6E63,   // func
        64'h0000_0070_7269_6E74,   // print
        64'h0000_0000_0076_6172,   // var
        64'h0000_0000_0000_6966,   // if
        64'h0000_0000_656C_7365,   // else
        64'h0000_0077_6869_6C65,   // while
        64'h0000_0062_7265_616B,   // break
        64'h636F_6E74_696E_7565,   // continue
        64'h0000_7265_7475_726E    // return
    };

    localparam logic [3:0] KW_LEN [KW_COUNT] = '{
        4'd3, 4'd4, 4'd5, 4'd4, 4'd5, 4'd3, 4'd2, 4'd4, 4'd5, 4'd5, 4'd8, 4'd6
    };

    localparam logic [7:0] OP_FIRST [OP_COUNT] = '{
        8'h3D, 8'h21, 8'h26, 8'h7C, 8'h3C, 8'h3E
    };
    localparam logic [7:0] OP_SECOND [OP_COUNT] = '{
        8'h3D, 8'h3D, 8'h26, 8'h7C, 8'h3D, 8'h3D
    };

    typedef struct packed {
        logic       hit;
        logic [2:0] idx;
    } op_hit_t;

    function automatic op_hit_t op_lookup(input logic [7:0] c);
        op_hit_t r;
        r = '0;
        for (int i = 0; i < OP_COUNT; i++)
        begin
            if (!r.hit && OP_FIRST[i] == c)
            begin
                r.hit = 1'b1;
                r.idx = 3'(i);
            end
        end
        return r;
    endfunction

    function automatic logic [4:0] word_kind(input logic [PREFIX_BITS-1:0] prefix,
                                             input logic [RUN_BITS-1:0] run);
        logic [4:0] k;
        k = KIND_NAME;
        if (run <= RUN_BITS'(MAX_KEYWORD_CHARS))
        begin
            for (int i = 0; i < KW_COUNT; i++)
            begin
                if (RUN_BITS'(KW_LEN[i]) == run && KW_TEXT[i] == prefix)
                begin
                    k = KIND_KW_BASE + 5'(i);
                end
            end
        end
        return k;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/script_lexer_tokenizer.sv =====
// ----------------------------------------------------------------------------
// script_lexer_tokenizer
// Streaming lexer: one source byte per beat in, one token per beat out.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid/in_stall carries ch, one source byte per beat; a
//   zero byte ends the input. Output channel out_valid/out_stall carries one
//   token per beat with its kind, symbol, line, start offset, length, error
//   code and a last flag on the final token caused by a given byte.
//   Each accepted byte is scanned in the cycle it is taken and its tokens
//   (zero to three) are written into a four-entry result queue; the first
//   is shown from the registered queue, behind any tokens already waiting.
//   Throughput is one byte per cycle while out_stall is low and bytes give
//   at most one token each. in_stall rises whenever the queue holds two or
//   more tokens, so a byte that gives two or three tokens (a token closed by
//   a symbol, newline or end byte) holds off the next byte until the queue is
//   down to one token, and a stalled receiver backs up into in_stall.
//   After end of input or an error token the lexer halts: further bytes are
//   taken and dropped. Reset clears the scan state and empties the queue;
//   in_stall is low straight out of reset.
// ----------------------------------------------------------------------------
`default_nettype none

`include "script_lexer_tokenizer_assert.svh"

module script_lexer_tokenizer
    import lextok_pkg::*;
#(
    parameter int LINE_BITS   = 24,
    parameter int OFFSET_BITS = 32
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    output logic                        in_stall,
    input  wire logic [7:0]             ch,
    output logic                        out_valid,
    input  wire logic                   out_stall,
    output logic [4:0]                  token_kind,
    output logic [7:0]                  symbol_char,
    output logic [LINE_BITS-1:0]        line_no,
    output logic [OFFSET_BITS-1:0]      start_offset,
    output logic [RUN_BITS-1:0]         text_length,
    output logic [1:0]                  error_code,
    output logic                        last
);

    typedef struct packed {
        logic [4:0]             kind;
        logic [7:0]             sym;
        logic [LINE_BITS-1:0]   line;
        logic [OFFSET_BITS-1:0] start;
        logic [RUN_BITS-1:0]    len;
        logic [1:0]             err;
        logic                   last;
    } result_t;

    localparam logic [LINE_BITS-1:0] LINE_MAX = {LINE_BITS{1'b1}};
    localparam logic [RUN_BITS-1:0]  RUN_MAX  = {RUN_BITS{1'b1}};

    // scan state
    scan_mode_t             mode_reg, mode_next;
    logic                   nis_reg, nis_next;
    logic [LINE_BITS-1:0]   line_reg, line_next;
    logic [OFFSET_BITS-1:0] pos_reg, pos_next;
    logic [OFFSET_BITS-1:0] tstart_reg, tstart_next;
    logic [LINE_BITS-1:0]   tline_reg, tline_next;
    logic [PREFIX_BITS-1:0] prefix_reg, prefix_next;
    logic [RUN_BITS-1:0]    run_reg, run_next;
    logic [7:0]             psym_reg, psym_next;
    logic                   esc_reg, esc_next;
    logic                   halted_reg, halted_next;

    // result queue
    result_t                q_mem [QDEPTH];
    logic [QPTR_BITS-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [QPTR_BITS:0]     count_reg, count_next;

    logic                   accept_in, pop;
    logic [1:0]             n_res, push_n;
    result_t                res [MAX_PUSH];

    // byte classes
    logic                   is_digit, is_wstart, is_wpart;
    op_hit_t                op_c, op_p;
    logic [LINE_BITS-1:0]   line_inc;
    logic [RUN_BITS-1:0]    run_inc;
    logic [OFFSET_BITS-1:0] pos_inc;

    // first-phase decode
    logic                   pend_valid;
    logic [4:0]             pend_kind;
    logic [7:0]             pend_sym;
    logic [RUN_BITS-1:0]    pend_len;
    logic [1:0]             pend_err;
    logic                   do_idle;
    logic                   nis_mid;
    logic [4:0]             wkind;

    // idle-phase results
    logic [1:0]             idl_n;
    logic [4:0]             idl0_kind, idl1_kind;
    logic [7:0]             idl0_sym;

    assign is_digit  = (ch inside {[8'h30:8'h39]});
    assign is_wstart = (ch inside {[8'h61:8'h7A], [8'h41:8'h5A], CH_UNDERLINE});
    assign is_wpart  = is_wstart || is_digit;
    assign op_c      = op_lookup(ch);
    assign op_p      = op_lookup(psym_reg);
    assign line_inc  = (line_reg == LINE_MAX) ? line_reg : line_reg + 1'b1;
    assign run_inc   = (run_reg == RUN_MAX) ? run_reg : run_reg + 1'b1;
    assign pos_inc   = pos_reg + 1'b1;
    assign wkind     = word_kind(prefix_reg, run_reg);

    // token closed by this byte, before the byte's own handling
    always_comb
    begin
        pend_valid = 1'b0;
        pend_kind  = KIND_EOF;
        pend_sym   = 8'h00;
        pend_len   = '0;
        pend_err   = ERR_NONE;
        do_idle    = 1'b0;
        nis_mid    = nis_reg;
        case (mode_reg)
            MODE_COMMENT:
            begin
                do_idle = (ch == CH_NUL) || (ch == CH_LF);
            end
            MODE_WORD:
            begin
                if (!is_wpart)
                begin
                    pend_valid = 1'b1;
                    pend_kind  = wkind;
                    pend_len   = (wkind == KIND_NAME) ? run_reg : '0;
                    nis_mid    = 1'b0;
                    do_idle    = 1'b1;
                end
            end
            MODE_NUM_INT, MODE_NUM_FRAC:
            begin
                if (is_digit || (ch == CH_DOT && mode_reg == MODE_NUM_INT))
                begin
                    pend_valid = 1'b0;
                end
                else if (is_wpart)
                begin
                    pend_valid = 1'b1;
                    pend_kind  = KIND_EOF;
                    pend_len   = run_reg;
                    pend_err   = ERR_BAD_NUMBER;
                end
                else
                begin
                    pend_valid = 1'b1;
                    pend_kind  = KIND_NUMBER;
                    pend_len   = run_reg;
                    nis_mid    = 1'b0;
                    do_idle    = 1'b1;
                end
            end
            MODE_STRING:
            begin
                if (ch == CH_NUL)
                begin
                    pend_valid = 1'b1;
                    pend_kind  = KIND_EOF;
                    pend_len   = run_reg;
                    pend_err   = ERR_OPEN_STRING;
                end
                else if (!esc_reg && ch == CH_QUOTE)
                begin
                    pend_valid = 1'b1;
                    pend_kind  = KIND_STRING;
                    pend_len   = run_reg;
                end
            end
            MODE_SYM:
            begin
                nis_mid    = 1'b1;
                pend_valid = 1'b1;
                if (op_p.hit && OP_SECOND[op_p.idx] == ch)
                begin
                    pend_kind = KIND_OP_BASE + 5'(op_p.idx);
                end
                else
                begin
                    pend_kind = KIND_SYMBOL;
                    pend_sym  = psym_reg;
                    do_idle   = 1'b1;
                end
            end
            default:
            begin
                do_idle = 1'b1;
            end
        endcase
    end

    // tokens raised by the byte itself when scanned between tokens
    always_comb
    begin
        idl_n     = 2'd0;
        idl0_kind = KIND_EOF;
        idl1_kind = KIND_EOF;
        idl0_sym  = 8'h00;
        if (do_idle)
        begin
            if (ch == CH_NUL)
            begin
                if (!nis_mid)
                begin
                    idl0_kind = KIND_EOL;
                    idl_n     = 2'd2;
                end
                else
                begin
                    idl_n = 2'd1;
                end
            end
            else if (ch == CH_LF)
            begin
                if (!nis_mid)
                begin
                    idl0_kind = KIND_EOL;
                    idl_n     = 2'd1;
                end
            end
            else if ((ch inside {CH_SPACE, CH_TAB, CH_CR, CH_HASH, CH_QUOTE})
                     || is_wpart || op_c.hit)
            begin
                idl_n = 2'd0;
            end
            else
            begin
                idl0_kind = KIND_SYMBOL;
                idl0_sym  = ch;
                idl_n     = 2'd1;
            end
        end
    end

    // next scan state
    always_comb
    begin
        mode_next   = mode_reg;
        nis_next    = nis_mid;
        line_next   = line_reg;
        pos_next    = pos_inc;
        tstart_next = tstart_reg;
        tline_next  = tline_reg;
        prefix_next = prefix_reg;
        run_next    = run_reg;
        psym_next   = psym_reg;
        esc_next    = esc_reg;
        halted_next = halted_reg;
        case (mode_reg)
            MODE_WORD:
            begin
                if (is_wpart)
                begin
                    if (run_reg < RUN_BITS'(MAX_KEYWORD_CHARS))
                    begin
                        prefix_next = {prefix_reg[PREFIX_BITS-9:0], ch};
                    end
                    run_next = run_inc;
                end
            end
            MODE_NUM_INT, MODE_NUM_FRAC:
            begin
                if (is_digit)
                begin
                    run_next = run_inc;
                end
                else if (ch == CH_DOT && mode_reg == MODE_NUM_INT)
                begin
                    run_next  = run_inc;
                    mode_next = MODE_NUM_FRAC;
                end
                else if (is_wpart)
                begin
                    halted_next = 1'b1;
                    mode_next   = MODE_IDLE;
                end
            end
            MODE_STRING:
            begin
                if (ch == CH_NUL)
                begin
                    halted_next = 1'b1;
                    mode_next   = MODE_IDLE;
                end
                else if (esc_reg)
                begin
                    esc_next = 1'b0;
                    run_next = run_inc;
                    if (ch == CH_LF)
                    begin
                        line_next = line_inc;
                    end
                end
                else if (ch == CH_BACKSLASH)
                begin
                    esc_next = 1'b1;
                    run_next = run_inc;
                end
                else if (ch == CH_QUOTE)
                begin
                    nis_next  = 1'b0;
                    mode_next = MODE_IDLE;
                end
                else
                begin
                    run_next = run_inc;
                    if (ch == CH_LF)
                    begin
                        line_next = line_inc;
                    end
                end
            end
            MODE_SYM:
            begin
                if (!do_idle)
                begin
                    mode_next = MODE_IDLE;
                end
            end
            default:
            begin
                mode_next = mode_reg;
            end
        endcase

        if (do_idle)
        begin
            mode_next = MODE_IDLE;
            if (ch == CH_NUL)
            begin
                halted_next = 1'b1;
            end
            else if (ch == CH_LF)
            begin
                nis_next  = 1'b1;
                line_next = line_inc;
            end
            else if (ch == CH_HASH)
            begin
                mode_next = MODE_COMMENT;
            end
            else if (ch inside {CH_SPACE, CH_TAB, CH_CR})
            begin
                mode_next = MODE_IDLE;
            end
            else if (is_wstart || is_digit || ch == CH_QUOTE || op_c.hit)
            begin
                // open a new token
                tstart_next = pos_reg;
                tline_next  = line_reg;
                run_next    = '0;
                prefix_next = '0;
                esc_next    = 1'b0;
                if (is_wstart)
                begin
                    mode_next   = MODE_WORD;
                    run_next    = RUN_BITS'(1);
                    prefix_next = PREFIX_BITS'(ch);
                end
                else if (is_digit)
                begin
                    mode_next = MODE_NUM_INT;
                    run_next  = RUN_BITS'(1);
                end
                else if (ch == CH_QUOTE)
                begin
                    mode_next   = MODE_STRING;
                    tstart_next = pos_inc;
                end
                else
                begin
                    mode_next = MODE_SYM;
                    psym_next = ch;
                end
            end
            else
            begin
                nis_next = !(ch inside {CH_RPAREN, CH_RBRACK, CH_RBRACE});
            end
        end
    end

    // order the results of this byte: closed token first, then idle tokens
    always_comb
    begin
        result_t p_res, i0_res, i1_res;
        p_res  = '{kind: pend_kind, sym: pend_sym, line: tline_reg, start: tstart_reg,
                   len: pend_len, err: pend_err, last: 1'b0};
        i0_res = '{kind: idl0_kind, sym: idl0_sym, line: line_reg, start: pos_reg,
                   len: '0, err: ERR_NONE, last: 1'b0};
        i1_res = '{kind: idl1_kind, sym: 8'h00, line: line_reg, start: pos_reg,
                   len: '0, err: ERR_NONE, last: 1'b0};
        if (halted_reg)
        begin
            n_res = 2'd0;
        end
        else
        begin
            n_res = idl_n + {1'b0, pend_valid};
        end
        if (pend_valid)
        begin
            res[0] = p_res;
            res[1] = i0_res;
            res[2] = i1_res;
        end
        else
        begin
            res[0] = i0_res;
            res[1] = i1_res;
            res[2] = i1_res;
        end
        for (int i = 0; i < MAX_PUSH; i++)
        begin
            res[i].last = (2'(i) == n_res - 2'd1);
        end
    end

    assign in_stall  = (count_reg > (QPTR_BITS+1)'(1));
    assign accept_in = in_valid && !in_stall;
    assign out_valid = (count_reg != '0);
    assign pop       = out_valid && !out_stall;
    assign push_n    = accept_in ? n_res : 2'd0;
    assign count_next = count_reg + (QPTR_BITS+1)'(push_n) - (QPTR_BITS+1)'(pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_IDLE;
            nis_reg    <= 1'b1;
            line_reg   <= '0;
            pos_reg    <= '0;
            tstart_reg <= '0;
            tline_reg  <= '0;
            prefix_reg <= '0;
            run_reg    <= '0;
            psym_reg   <= 8'h00;
            esc_reg    <= 1'b0;
            halted_reg <= 1'b0;
        end
        else if (accept_in && !halted_reg)
        begin
            mode_reg   <= mode_next;
            nis_reg    <= nis_next;
            line_reg   <= line_next;
            pos_reg    <= pos_next;
            tstart_reg <= tstart_next;
            tline_reg  <= tline_next;
            prefix_reg <= prefix_next;
            run_reg    <= run_next;
            psym_reg   <= psym_next;
            esc_reg    <= esc_next;
            halted_reg <= halted_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_reg + push_n;
            rd_ptr_reg <= rd_ptr_reg + QPTR_BITS'(pop);
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < MAX_PUSH; i++)
        begin
            if (2'(i) < push_n)
            begin
                q_mem[wr_ptr_reg + QPTR_BITS'(i)] <= res[i];
            end
        end
    end

    assign token_kind   = q_mem[rd_ptr_reg].kind;
    assign symbol_char  = q_mem[rd_ptr_reg].sym;
    assign line_no      = q_mem[rd_ptr_reg].line;
    assign start_offset = q_mem[rd_ptr_reg].start;
    assign text_length  = q_mem[rd_ptr_reg].len;
    assign error_code   = q_mem[rd_ptr_reg].err;
    assign last         = q_mem[rd_ptr_reg].last;

    `LEX_ASSERT_IMP(a_queue_bound, 1'b1, count_reg <= (QPTR_BITS+1)'(QDEPTH), "result queue overflow")
    `LEX_ASSERT_NXT(a_halt_sticky, halted_reg, halted_reg, "halt released without reset")
    `LEX_ASSERT_IMP(a_halt_silent, accept_in && halted_reg, push_n == 2'd0, "token after halt")
    `LEX_ASSERT_NXT(a_push_shows, accept_in && push_n != 2'd0, out_valid, "pushed token not shown")

endmodule

`default_nettype wire

// ===== verif/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: script_lexer_tokenizer regression
// Streams one source text through the lexer, predicts each token beat from
// a scanner model kept alongside it, and compares every output beat in
// order. Short directed text first, then random token soup under three
// idling mixes, one name longer than any keyword, and an ending
// picked at random (clean end, bad number, open string).
// ----------------------------------------------------------------------------
module tb_top
    import lextok_pkg::*;
;

    localparam int IDLE_LIMIT      = 2000;
    localparam int DRAIN_CYCLES    = 16;
    localparam int LONG_NAME_CHARS = 24;

    // keyword order gives the kind offset from KIND_KW_BASE
    localparam bit [63:0] KW_PACKED [KW_COUNT] = '{
        "nil", "true", "false", "func", "print", "var",
        "if", "else", "while", "break", "continue", "return"
    };
    localparam bit [15:0] OP_PAIRS [OP_COUNT] = '{"==", "!=", "&&", "||", "<=", ">="};

    typedef struct packed {
        logic [4:0]  kind;
        logic [7:0]  sym;
        logic [23:0] lineno;
        logic [31:0] start_ofs;
        logic [15:0] len;
        logic [1:0]  err;
        logic        fin;
    } token_t;

    logic        clk;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    logic [7:0]  ch        = 8'h00;
    logic        out_stall = 1'b0;
    logic        in_stall;
    logic        out_valid;
    logic [4:0]  token_kind;
    logic [7:0]  symbol_char;
    logic [23:0] line_no;
    logic [31:0] start_offset;
    logic [15:0] text_length;
    logic [1:0]  error_code;
    logic        last;

    int          in_gap_pct    = 20;
    int          out_stall_pct = 77;
    int unsigned bytes_sent    = 0;
    int unsigned mismatches    = 0;
    int unsigned idle_cycles   = 0;
    int unsigned kw_turn       = 0;
    int unsigned op_turn       = 0;

    token_t token_queue[$];
    token_t byte_tokens[$];

    // scanner state mirrored from the lexer
    scan_mode_t  sc_mode;
    logic        sc_nl_space;
    logic [23:0] sc_line;
    logic [31:0] sc_pos;
    logic [31:0] sc_tok_start;
    logic [23:0] sc_tok_line;
    logic [63:0] sc_prefix;
    logic [15:0] sc_run;
    logic [7:0]  sc_op_char;
    logic        sc_escape;
    logic        sc_halted;

    script_lexer_tokenizer i_dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .ch           (ch),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .token_kind   (token_kind),
        .symbol_char  (symbol_char),
        .line_no      (line_no),
        .start_offset (start_offset),
        .text_length  (text_length),
        .error_code   (error_code),
        .last         (last)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // scanner model
    // ------------------------------------------------------------------
    function automatic bit is_digit(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic bit word_head(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == CH_UNDERLINE;
    endfunction

    function automatic bit word_part(input logic [7:0] c);
        return word_head(c) || is_digit(c);
    endfunction

    function automatic int op_slot(input logic [7:0] c);
        for (int i = 0; i < OP_COUNT; i++)
        begin
            if (OP_PAIRS[i][15:8] == c)
                return i;
        end
        return -1;
    endfunction

    function automatic logic [4:0] word_class();
        logic [4:0] k;
        k = KIND_NAME;
        if (sc_run <= 16'(MAX_KEYWORD_CHARS))
        begin
            for (int i = 0; i < KW_COUNT; i++)
            begin
                if (sc_prefix == KW_PACKED[i])
                    k = KIND_KW_BASE + 5'(i);
            end
        end
        return k;
    endfunction

    function automatic void line_up();
        if (sc_line != '1)
            sc_line++;
    endfunction

    function automatic void run_up();
        if (sc_run != '1)
            sc_run++;
    endfunction

    function automatic void emit(input logic [4:0] k, input logic [7:0] s,
                                 input logic [23:0] ln, input logic [31:0] st,
                                 input logic [15:0] len, input logic [1:0] e);
        token_t t;
        t.kind      = k;
        t.sym       = s;
        t.lineno    = ln;
        t.start_ofs = st;
        t.len       = len;
        t.err       = e;
        t.fin       = 1'b0;
        byte_tokens.push_back(t);
    endfunction

    function automatic void open_token(input scan_mode_t m, input logic [31:0] p);
        sc_mode      = m;
        sc_tok_start = p;
        sc_tok_line  = sc_line;
        sc_run       = '0;
        sc_prefix    = '0;
        sc_escape    = 1'b0;
    endfunction

    function automatic void halt_on(input logic [1:0] e);
        emit(KIND_EOF, 8'h00, sc_tok_line, sc_tok_start, sc_run, e);
        sc_halted = 1'b1;
        sc_mode   = MODE_IDLE;
    endfunction

    function automatic void scan_idle(input logic [7:0] c, input logic [31:0] p);
        sc_mode = MODE_IDLE;
        if (c == CH_NUL)
        begin
            if (!sc_nl_space)
                emit(KIND_EOL, 8'h00, sc_line, p, 16'd0, ERR_NONE);
            emit(KIND_EOF, 8'h00, sc_line, p, 16'd0, ERR_NONE);
            sc_halted = 1'b1;
        end
        else if (c == CH_SPACE || c == CH_TAB || c == CH_CR)
        begin
            // skip blanks
        end
        else if (c == CH_LF)
        begin
            if (!sc_nl_space)
            begin
                emit(KIND_EOL, 8'h00, sc_line, p, 16'd0, ERR_NONE);
                sc_nl_space = 1'b1;
            end
            line_up();
        end
        else if (c == CH_HASH)
            sc_mode = MODE_COMMENT;
        else if (word_head(c))
        begin
            open_token(MODE_WORD, p);
            sc_run    = 16'd1;
            sc_prefix = {56'd0, c};
        end
        else if (is_digit(c))
        begin
            open_token(MODE_NUM_INT, p);
            sc_run = 16'd1;
        end
        else if (c == CH_QUOTE)
            open_token(MODE_STRING, p + 32'd1);
        else if (op_slot(c) >= 0)
        begin
            open_token(MODE_SYM, p);
            sc_op_char = c;
        end
        else
        begin
            emit(KIND_SYMBOL, c, sc_line, p, 16'd0, ERR_NONE);
            sc_nl_space = !(c == CH_RPAREN || c == CH_RBRACK || c == CH_RBRACE);
        end
    endfunction

    function automatic void lex_byte(input logic [7:0] c);
        logic [31:0] p;
        logic [4:0]  k;
        int          slot;
        token_t      t;
        p = sc_pos;
        byte_tokens.delete();
        if (sc_halted)
            return;
        case (sc_mode)
            MODE_COMMENT:
            begin
                if (c == CH_NUL || c == CH_LF)
                    scan_idle(c, p);
            end
            MODE_WORD:
            begin
                if (word_part(c))
                begin
                    if (sc_run < 16'(MAX_KEYWORD_CHARS))
                        sc_prefix = {sc_prefix[55:0], c};
                    run_up();
                end
                else
                begin
                    k = word_class();
                    emit(k, 8'h00, sc_tok_line, sc_tok_start,
                         (k == KIND_NAME) ? sc_run : 16'd0, ERR_NONE);
                    sc_nl_space = 1'b0;
                    scan_idle(c, p);
                end
            end
            MODE_NUM_INT, MODE_NUM_FRAC:
            begin
                if (is_digit(c))
                    run_up();
                else if (c == CH_DOT && sc_mode == MODE_NUM_INT)
                begin
                    run_up();
                    sc_mode = MODE_NUM_FRAC;
                end
                else if (word_part(c))
                    halt_on(ERR_BAD_NUMBER);
                else
                begin
                    emit(KIND_NUMBER, 8'h00, sc_tok_line, sc_tok_start, sc_run, ERR_NONE);
                    sc_nl_space = 1'b0;
                    scan_idle(c, p);
                end
            end
            MODE_STRING:
            begin
                if (c == CH_NUL)
                    halt_on(ERR_OPEN_STRING);
                else if (sc_escape)
                begin
                    sc_escape = 1'b0;
                    run_up();
                    if (c == CH_LF)
                        line_up();
                end
                else if (c == CH_BACKSLASH)
                begin
                    sc_escape = 1'b1;
                    run_up();
                end
                else if (c == CH_QUOTE)
                begin
                    emit(KIND_STRING, 8'h00, sc_tok_line, sc_tok_start, sc_run, ERR_NONE);
                    sc_nl_space = 1'b0;
                    sc_mode     = MODE_IDLE;
                end
                else
                begin
                    run_up();
                    if (c == CH_LF)
                        line_up();
                end
            end
            MODE_SYM:
            begin
                slot        = op_slot(sc_op_char);
                sc_nl_space = 1'b1;
                if (slot >= 0 && OP_PAIRS[slot][7:0] == c)
                begin
                    emit(KIND_OP_BASE + 5'(slot), 8'h00, sc_tok_line, sc_tok_start,
                         16'd0, ERR_NONE);
                    sc_mode = MODE_IDLE;
                end
                else
                begin
                    emit(KIND_SYMBOL, sc_op_char, sc_tok_line, sc_tok_start, 16'd0, ERR_NONE);
                    scan_idle(c, p);
                end
            end
            default:
                scan_idle(c, p);
        endcase
        sc_pos = p + 32'd1;
        if (byte_tokens.size() > 0)
        begin
            t     = byte_tokens.pop_back();
            t.fin = 1'b1;
            byte_tokens.push_back(t);
            foreach (byte_tokens[i])
                token_queue.push_back(byte_tokens[i]);
        end
    endfunction

    // ------------------------------------------------------------------
    // input side
    // ------------------------------------------------------------------
    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(0, 99) < in_gap_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        ch       <= b;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        bytes_sent++;
        lex_byte(b);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i]);
    endtask

    task automatic send_packed(input logic [63:0] w);
        for (int i = 7; i >= 0; i--)
        begin
            if (w[8*i +: 8] != 8'h00)
                send_byte(w[8*i +: 8]);
        end
    endtask

    function automatic logic [7:0] word_char(input bit head);
        int unsigned r;
        r = $urandom_range(0, head ? 52 : 62);
        if (r < 26)
            return 8'("a" + r);
        else if (r < 52)
            return 8'("A" + r - 26);
        else if (r == 52)
            return CH_UNDERLINE;
        return 8'("0" + r - 53);
    endfunction

    function automatic logic [7:0] any_byte_but(input logic [7:0] x, input logic [7:0] y);
        logic [7:0] c;
        do
            c = 8'($urandom_range(1, 255));
        while (c == x || c == y);
        return c;
    endfunction

    // close comments and strings, end numbers, so the next piece cannot halt the scan
    task automatic settle();
        while (sc_mode inside {MODE_COMMENT, MODE_STRING, MODE_NUM_INT, MODE_NUM_FRAC})
        begin
            case (sc_mode)
                MODE_COMMENT: send_byte(CH_LF);
                MODE_STRING:  send_byte(CH_QUOTE);
                default:      send_byte($urandom_range(0, 1) ? CH_SPACE : ";");
            endcase
        end
    endtask

    task automatic send_piece();
        int unsigned pick;
        int unsigned n;
        string       sym_set   = "()[]{};,+-*/.:";
        string       blank_set = " \t\015\n\n";
        pick = $urandom_range(0, 99);
        settle();
        if (pick < 15)
        begin
            send_packed(KW_PACKED[kw_turn % KW_COUNT]);
            kw_turn++;
        end
        else if (pick < 30)
        begin
            if ($urandom_range(0, 2) == 0)
            begin
                // near miss on a keyword
                send_packed(KW_PACKED[$urandom_range(0, KW_COUNT - 1)]);
                send_byte(word_char(1'b0));
            end
            else
            begin
                send_byte(word_char(1'b1));
                repeat ($urandom_range(0, 10))
                    send_byte(word_char(1'b0));
            end
        end
        else if (pick < 42)
        begin
            repeat ($urandom_range(1, 4))
                send_byte(8'("0" + $urandom_range(0, 9)));
            if ($urandom_range(0, 1))
            begin
                send_byte(CH_DOT);
                repeat ($urandom_range(0, 3))
                    send_byte(8'("0" + $urandom_range(0, 9)));
            end
        end
        else if (pick < 52)
        begin
            send_byte(CH_QUOTE);
            n = $urandom_range(0, 6);
            repeat (n)
            begin
                pick = $urandom_range(0, 9);
                if (pick < 2)
                begin
                    send_byte(CH_BACKSLASH);
                    send_byte(8'($urandom_range(1, 255)));
                end
                else if (pick < 3)
                    send_byte(CH_LF);
                else
                    send_byte(any_byte_but(CH_QUOTE, CH_BACKSLASH));
            end
            send_byte(CH_QUOTE);
        end
        else if (pick < 64)
        begin
            if ($urandom_range(0, 9) < 7)
            begin
                send_byte(OP_PAIRS[op_turn % OP_COUNT][15:8]);
                send_byte(OP_PAIRS[op_turn % OP_COUNT][7:0]);
                op_turn++;
            end
            else
                send_byte(OP_PAIRS[$urandom_range(0, OP_COUNT - 1)][15:8]);
        end
        else if (pick < 74)
            send_byte(sym_set[$urandom_range(0, 13)]);
        else if (pick < 86)
            send_byte(blank_set[$urandom_range(0, 4)]);
        else if (pick < 92)
        begin
            send_byte(CH_HASH);
            repeat ($urandom_range(0, 5))
                send_byte(any_byte_but(CH_LF, CH_LF));
            send_byte(CH_LF);
        end
        else
            send_byte(8'($urandom_range(1, 255)));
    endtask

    // ------------------------------------------------------------------
    // output side
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatches++;
        $display("%0t ns: %s got 0x%0h want 0x%0h", $time, what, got, want);
    endtask

    always @(posedge clk)
    begin : token_check
        token_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (token_queue.size() == 0)
                report_mismatch("token beat with none due, kind", 32'(token_kind), 32'd0);
            else
            begin
                want = token_queue.pop_front();
                if (token_kind !== want.kind)
                    report_mismatch("token_kind", 32'(token_kind), 32'(want.kind));
                if (symbol_char !== want.sym)
                    report_mismatch("symbol_char", 32'(symbol_char), 32'(want.sym));
                if (line_no !== want.lineno)
                    report_mismatch("line_no", 32'(line_no), 32'(want.lineno));
                if (start_offset !== want.start_ofs)
                    report_mismatch("start_offset", start_offset, want.start_ofs);
                if (text_length !== want.len)
                    report_mismatch("text_length", 32'(text_length), 32'(want.len));
                if (error_code !== want.err)
                    report_mismatch("error_code", 32'(error_code), 32'(want.err));
                if (last !== want.fin)
                    report_mismatch("last", 32'(last), 32'(want.fin));
            end
        end
        out_stall <= ($urandom_range(0, 99) < out_stall_pct);
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("script_lexer_tokenizer regression: fail");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------
    task automatic test_directed();
        // leading newline, eol after ')' and '}', comment, escaped quote and
        // newline in a string, split and joined operators, fraction ended by
        // a dot, high bytes as symbols
        send_text("\n)\n#c\n}\015\n\"\\\"\n\"\n<<=9.5.\377\200A_z ");
    endtask

    task automatic test_random_text(input int gap_pct, input int stall_pct,
                                    input int unsigned upto);
        in_gap_pct    = gap_pct;
        out_stall_pct = stall_pct;
        while (bytes_sent < upto)
            send_piece();
    endtask

    task automatic test_long_name();
        in_gap_pct    = 0;
        out_stall_pct = 0;
        settle();
        send_byte(word_char(1'b1));
        repeat (LONG_NAME_CHARS)
            send_byte(word_char(1'b0));
        send_byte(CH_SPACE);
    endtask

    task automatic test_end_of_input();
        in_gap_pct    = 20;
        out_stall_pct = 20;
        settle();
        case ($urandom_range(0, 5))
            0:
            begin
                send_byte("w");
                send_byte("x");
            end
            1: send_packed(KW_PACKED[$urandom_range(0, KW_COUNT - 1)]);
            2: send_byte("7");
            3:
            begin
                send_byte("1");
                send_byte(CH_DOT);
                send_byte($urandom_range(0, 1) ? CH_UNDERLINE : "Q");
            end
            4:
            begin
                send_byte(CH_QUOTE);
                send_byte("a");
                send_byte(CH_BACKSLASH);
            end
            default: send_byte("=");
        endcase
        send_byte(CH_NUL);
        // halted: these beats must be dropped
        repeat (4)
            send_byte(8'($urandom_range(0, 255)));
        in_valid <= 1'b0;
    endtask

    initial
    begin
        sc_mode      = MODE_IDLE;
        sc_nl_space  = 1'b1;
        sc_line      = '0;
        sc_pos       = '0;
        sc_tok_start = '0;
        sc_tok_line  = '0;
        sc_prefix    = '0;
        sc_run       = '0;
        sc_op_char   = '0;
        sc_escape    = 1'b0;
        sc_halted    = 1'b0;
        repeat (4)
            @(posedge clk);
        rst_n <= 1'b1;
        test_directed();
        test_random_text(20, 77, 100);
        test_random_text(77, 20, 175);
        test_random_text(0, 0, 250);
        test_long_name();
        test_end_of_input();
        while (token_queue.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);
        if (mismatches == 0)
            $display("script_lexer_tokenizer regression: pass");
        else
            $display("script_lexer_tokenizer regression: fail");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/lextok_pkg.sv
rtl/core/script_lexer_tokenizer.sv
verif/tb_top.sv
